### hdl/psc_pkg.sv
// shared types, constants and arithmetic helpers for the pressure sensor compensation unit
// no dependencies
`default_nettype none

package psc_pkg;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_TRIM       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TRIM_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TRIM_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TRIM_LAST = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM_TRIM        = 3'd4;

   localparam logic [31:0] PRESS_OFS    = 32'd64000;
   localparam logic [31:0] PRESS_BASE   = 32'd1048576;
   localparam logic [31:0] PRESS_SCALE  = 32'd3125;
   localparam logic [31:0] HUM_OFS      = 32'd76800;
   localparam logic [31:0] HUM_MAX_Q22  = 32'd419430400;
   localparam logic [31:0] HUM_RND      = 32'd16384;
   localparam logic [31:0] HUM_BIAS     = 32'd2097152;
   localparam logic [31:0] HUM_RND2     = 32'd8192;
   localparam logic [31:0] P1_BIAS      = 32'd32768;
   localparam logic [31:0] TEMP_RND     = 32'd128;

   localparam int unsigned FRONT_STAGES = 13;
   localparam int unsigned DIV_STAGES   = 32;
   localparam int unsigned BACK_STAGES  = 3;
   localparam int unsigned LATENCY      = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
      logic [15:0] raw_humidity;
   } psc_req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_pa;
      logic               pressure_invalid;
      logic [16:0]        humidity_q10;
   } psc_rsp_type;

   // trim coefficients, each extended to a 32-bit word
   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
   } psc_trim_type;

   // divider stage payload
   typedef struct packed {
      logic [31:0] num;
      logic [31:0] den;
      logic [31:0] quo;
      logic [31:0] rem;
      logic        bad;
      logic        sh;
      logic [31:0] temp;
      logic [16:0] hum;
   } psc_div_type;

   function automatic logic [31:0] sra(input logic [31:0] x, input int unsigned n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = {32'b0, a} * {32'b0, b};
      return p[31:0];
   endfunction

endpackage

`default_nettype wire

### hdl/pressure_sensor_compensation_unit.sv
// throughput: one request per cycle, busy is low except right after reset
// stages: 13 multiply stages, 32 divider stages (one quotient bit each), 3 correction stages
// reset: synchronous, clears the valid bits and the trim registers; no results are pending after it
// results are strobed for one cycle and cannot be stalled by the receiver
// depends on psc_pkg, psc_front, psc_div, psc_back
`default_nettype none

module pressure_sensor_compensation_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire psc_pkg::psc_req_type             req_data,
   output logic                                  rsp_valid,
   output psc_pkg::psc_rsp_type                  rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [psc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [psc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import psc_pkg::*;

   // trim registers; to be written only while no request is in flight, which the block itself does not enforce
   logic [47:0] temp_trim_ff;
   logic [63:0] press_lo_ff, press_hi_ff, hum_trim_ff;
   logic [15:0] press_last_ff;
   logic        busy_ff;

   psc_trim_type trim;
   logic         accept;
   logic         f_vld, d_vld;
   psc_div_type  f_div, d_div;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff  <= '0;
         press_lo_ff   <= '0;
         press_hi_ff   <= '0;
         press_last_ff <= '0;
         hum_trim_ff   <= '0;
         busy_ff       <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TEMP_TRIM:       temp_trim_ff  <= csr_wdata[47:0];
               CSR_PRESS_TRIM_LOW:  press_lo_ff   <= csr_wdata;
               CSR_PRESS_TRIM_HIGH: press_hi_ff   <= csr_wdata;
               CSR_PRESS_TRIM_LAST: press_last_ff <= csr_wdata[15:0];
               CSR_HUM_TRIM:        hum_trim_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // unpack the trim words into sign or zero extended coefficients
   always_comb begin
      trim.t1 = {16'b0, temp_trim_ff[15:0]};
      trim.t2 = {{16{temp_trim_ff[31]}}, temp_trim_ff[31:16]};
      trim.t3 = {{16{temp_trim_ff[47]}}, temp_trim_ff[47:32]};
      trim.p1 = {16'b0, press_lo_ff[15:0]};
      trim.p2 = {{16{press_lo_ff[31]}}, press_lo_ff[31:16]};
      trim.p3 = {{16{press_lo_ff[47]}}, press_lo_ff[47:32]};
      trim.p4 = {{16{press_lo_ff[63]}}, press_lo_ff[63:48]};
      trim.p5 = {{16{press_hi_ff[15]}}, press_hi_ff[15:0]};
      trim.p6 = {{16{press_hi_ff[31]}}, press_hi_ff[31:16]};
      trim.p7 = {{16{press_hi_ff[47]}}, press_hi_ff[47:32]};
      trim.p8 = {{16{press_hi_ff[63]}}, press_hi_ff[63:48]};
      trim.p9 = {{16{press_last_ff[15]}}, press_last_ff};
      // h1 and h3 are unsigned bytes
      trim.h1 = {24'b0, hum_trim_ff[7:0]};
      trim.h2 = {{16{hum_trim_ff[23]}}, hum_trim_ff[23:8]};
      trim.h3 = {24'b0, hum_trim_ff[31:24]};
      trim.h4 = {{20{hum_trim_ff[43]}}, hum_trim_ff[43:32]};
      trim.h5 = {{20{hum_trim_ff[55]}}, hum_trim_ff[55:44]};
      trim.h6 = {{24{hum_trim_ff[63]}}, hum_trim_ff[63:56]};
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   // multiply stages for temperature, humidity and the pressure dividend and divisor
   psc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (accept),
      .in_req  (req_data),
      .trim    (trim),
      .out_vld (f_vld),
      .out_div (f_div)
   );

   // pressure division, a zero divisor is flagged and masked at the end
   psc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (f_vld),
      .in_div  (f_div),
      .out_vld (d_vld),
      .out_div (d_div)
   );

   // second order pressure correction and the result register
   psc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (d_vld),
      .in_div  (d_div),
      .trim    (trim),
      .out_vld (rsp_valid),
      .out_rsp (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pressure_invalid |-> rsp_data.pressure_pa == '0)
      else $error("invalid pressure result is not zero");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.humidity_q10 <= 17'd102400)
      else $error("humidity above clamp");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##48 rsp_valid)
      else $error("request lost in pipeline");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 48))
      else $error("result without request");
`endif

endmodule

`default_nettype wire

### hdl/psc_front.sv
// front pipeline: fine temperature, temperature, pressure terms and humidity
// depends on psc_pkg
`default_nettype none

module psc_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_vld,
   input  wire psc_pkg::psc_req_type in_req,
   input  wire psc_pkg::psc_trim_type trim,
   output logic                      out_vld,
   output psc_pkg::psc_div_type      out_div
);
   import psc_pkg::*;

   typedef struct packed {
      logic [31:0] adc_p, adc_h;
      logic [31:0] ta, td, tf, temp;
      logic [31:0] pa, pd, ha;
      logic [31:0] pdd, ap5, ap2, hb_m, ha6, ha3;
      logic [31:0] b, q, hb, bb, a2, hd, a3m, pn;
      logic [31:0] hprod, hd4, sq, m;
      logic        bad;
      logic [16:0] hum;
   } stage_type;

   stage_type             s_ff [1:FRONT_STAGES];
   stage_type             s_in [1:FRONT_STAGES];
   logic [FRONT_STAGES:1] vld_ff;
   logic [FRONT_STAGES:1] vld_in;

   logic [31:0] adc_t, t_x, t_d, hv;

   always_comb begin
      adc_t = {12'b0, in_req.raw_temperature};
      t_x   = (adc_t >> 3) - (trim.t1 << 1);
      t_d   = (adc_t >> 4) - trim.t1;
      hv    = '0;

      vld_in = {vld_ff[FRONT_STAGES-1:1], in_vld};

      // temperature products
      s_in[1]       = '0;
      s_in[1].adc_p = {12'b0, in_req.raw_pressure};
      s_in[1].adc_h = {16'b0, in_req.raw_humidity};
      s_in[1].ta    = mul32(t_x, trim.t2);
      s_in[1].td    = mul32(t_d, t_d);

      s_in[2]    = s_ff[1];
      s_in[2].ta = sra(s_ff[1].ta, 11);
      s_in[2].td = mul32(sra(s_ff[1].td, 12), trim.t3);

      s_in[3]    = s_ff[2];
      s_in[3].tf = s_ff[2].ta + sra(s_ff[2].td, 14);

      // centidegrees and the offsets for pressure and humidity
      s_in[4]      = s_ff[3];
      s_in[4].temp = sra((s_ff[3].tf << 2) + s_ff[3].tf + TEMP_RND, 8);
      s_in[4].pa   = sra(s_ff[3].tf, 1) - PRESS_OFS;
      s_in[4].pd   = sra(sra(s_ff[3].tf, 1) - PRESS_OFS, 2);
      s_in[4].ha   = s_ff[3].tf - HUM_OFS;

      s_in[5]      = s_ff[4];
      s_in[5].pdd  = mul32(s_ff[4].pd, s_ff[4].pd);
      s_in[5].ap5  = mul32(s_ff[4].pa, trim.p5);
      s_in[5].ap2  = mul32(trim.p2, s_ff[4].pa);
      s_in[5].hb_m = mul32(trim.h5, s_ff[4].ha);
      s_in[5].ha6  = mul32(s_ff[4].ha, trim.h6);
      s_in[5].ha3  = mul32(s_ff[4].ha, trim.h3);

      s_in[6]     = s_ff[5];
      s_in[6].b   = mul32(sra(s_ff[5].pdd, 11), trim.p6);
      s_in[6].q   = mul32(trim.p3, sra(s_ff[5].pdd, 13));
      s_in[6].hb  = sra((s_ff[5].adc_h << 14) - (trim.h4 << 20) - s_ff[5].hb_m + HUM_RND, 15);
      s_in[6].ha6 = sra(s_ff[5].ha6, 10);
      s_in[6].ha3 = sra(s_ff[5].ha3, 11) + P1_BIAS;

      s_in[7]    = s_ff[6];
      s_in[7].bb = sra(s_ff[6].b + (s_ff[6].ap5 << 1), 2) + (trim.p4 << 16);
      s_in[7].a2 = sra(sra(s_ff[6].q, 3) + sra(s_ff[6].ap2, 1), 18);
      s_in[7].hd = sra(mul32(s_ff[6].ha6, s_ff[6].ha3), 10) + HUM_BIAS;

      s_in[8]     = s_ff[7];
      s_in[8].a3m = mul32(P1_BIAS + s_ff[7].a2, trim.p1);
      s_in[8].pn  = mul32((PRESS_BASE - s_ff[7].adc_p) - sra(s_ff[7].bb, 12), PRESS_SCALE);
      s_in[8].hd  = sra(mul32(s_ff[7].hd, trim.h2) + HUM_RND2, 14);

      s_in[9]       = s_ff[8];
      s_in[9].hprod = mul32(s_ff[8].hb, s_ff[8].hd);
      s_in[9].a3m   = sra(s_ff[8].a3m, 15);

      s_in[10]     = s_ff[9];
      s_in[10].hd4 = sra(s_ff[9].hprod, 15);
      s_in[10].bad = (s_ff[9].a3m == '0);

      s_in[11]    = s_ff[10];
      s_in[11].sq = mul32(s_ff[10].hd4, s_ff[10].hd4);

      s_in[12]   = s_ff[11];
      s_in[12].m = mul32(sra(s_ff[11].sq, 7), trim.h1);

      // humidity clamp to 0..100 %RH in q10.22 before the final shift
      hv = s_ff[12].hprod - sra(s_ff[12].m, 4);
      if (hv[31]) begin
         hv = '0;
      end else if (hv > HUM_MAX_Q22) begin
         hv = HUM_MAX_Q22;
      end
      s_in[13]     = s_ff[12];
      s_in[13].hum = hv[28:12];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      s_ff <= s_in;
   end

   // small dividends are doubled first; large ones are divided as they are and the quotient doubled afterwards
   always_comb begin
      out_vld      = vld_ff[FRONT_STAGES];
      out_div      = '0;
      out_div.sh   = s_ff[FRONT_STAGES].pn[31];
      out_div.num  = s_ff[FRONT_STAGES].pn[31] ? s_ff[FRONT_STAGES].pn
                                               : (s_ff[FRONT_STAGES].pn << 1);
      out_div.den  = s_ff[FRONT_STAGES].a3m;
      out_div.bad  = s_ff[FRONT_STAGES].bad;
      out_div.temp = s_ff[FRONT_STAGES].temp;
      out_div.hum  = s_ff[FRONT_STAGES].hum;
   end

endmodule

`default_nettype wire

### hdl/psc_div.sv
// pipelined restoring divider, one quotient bit per stage, side data travels along
// depends on psc_pkg
`default_nettype none

module psc_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_vld,
   input  wire psc_pkg::psc_div_type in_div,
   output logic                      out_vld,
   output psc_pkg::psc_div_type      out_div
);
   import psc_pkg::*;

   psc_div_type           d_ff [0:DIV_STAGES-1];
   logic [DIV_STAGES-1:0] vld_ff;

   function automatic psc_div_type div_step(input psc_div_type s);
      psc_div_type r;
      logic [32:0] part;
      r    = s;
      part = {s.rem, s.num[31]};
      if (part >= {1'b0, s.den}) begin
         r.rem = 32'(part - {1'b0, s.den});
         r.quo = {s.quo[30:0], 1'b1};
      end else begin
         r.rem = part[31:0];
         r.quo = {s.quo[30:0], 1'b0};
      end
      r.num = s.num << 1;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      d_ff[0] <= div_step(in_div);
      for (int k = 1; k < DIV_STAGES; k++) begin
         d_ff[k] <= div_step(d_ff[k-1]);
      end
   end

   assign out_vld = vld_ff[DIV_STAGES-1];
   assign out_div = d_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

### hdl/psc_back.sv
// back pipeline: pressure correction after the division and the result register
// depends on psc_pkg
`default_nettype none

module psc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_vld,
   input  wire psc_pkg::psc_div_type  in_div,
   input  wire psc_pkg::psc_trim_type trim,
   output logic                       out_vld,
   output psc_pkg::psc_rsp_type       out_rsp
);
   import psc_pkg::*;

   typedef struct packed {
      logic [31:0] p, sq, pb;
      logic        bad;
      logic [31:0] temp;
      logic [16:0] hum;
   } back_type;

   back_type    b1_ff, b1_in, b2_ff, b2_in;
   psc_rsp_type rsp_ff, rsp_in;
   logic [2:0]  vld_ff;
   logic [31:0] p0, corr;

   always_comb begin
      p0 = in_div.sh ? (in_div.quo << 1) : in_div.quo;
      b1_in      = '0;
      b1_in.p    = p0;
      b1_in.sq   = mul32(p0 >> 3, p0 >> 3);
      b1_in.pb   = mul32(p0 >> 2, trim.p8);
      b1_in.bad  = in_div.bad;
      b1_in.temp = in_div.temp;
      b1_in.hum  = in_div.hum;

      b2_in    = b1_ff;
      b2_in.sq = sra(mul32(trim.p9, b1_ff.sq >> 13), 12);
      b2_in.pb = sra(b1_ff.pb, 13);

      corr = b2_ff.p + sra(b2_ff.sq + b2_ff.pb + trim.p7, 4);
      rsp_in.temperature_centi = $signed(b2_ff.temp);
      rsp_in.pressure_pa       = b2_ff.bad ? '0 : corr;
      rsp_in.pressure_invalid  = b2_ff.bad;
      rsp_in.humidity_q10      = b2_ff.hum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_vld};
      end
      b1_ff  <= b1_in;
      b2_ff  <= b2_in;
      rsp_ff <= rsp_in;
   end

   assign out_vld = vld_ff[2];
   assign out_rsp = rsp_ff;

endmodule

`default_nettype wire

### dv/psc_checker.sv
// result checker for the pressure sensor compensation unit: mirrors trim writes,
// predicts each accepted request and compares strobed results; depends on psc_pkg
`timescale 1ns / 100ps

module psc_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic                             busy,
   input  wire psc_pkg::psc_req_type             req_data,
   input  wire logic                             rsp_valid,
   input  wire psc_pkg::psc_rsp_type             rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [psc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [psc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                    fail_count,
   output int                                    pending_count
);
   import psc_pkg::*;

   logic [47:0] temp_trim;
   logic [63:0] press_lo, press_hi, hum_trim;
   logic [15:0] press_p9;
   psc_rsp_type expected_q[$];

   function automatic logic [31:0] asr(input logic [31:0] x, input int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx(input logic [63:0] v, input int lo, input int w);
      logic [63:0] s;
      s = (v >> lo) << (64 - w);
      return 32'($signed(s) >>> (64 - w));
   endfunction

   function automatic psc_rsp_type compensate(input psc_req_type r);
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic [31:0] at, ap, ah, a, b, d, tf, p;
      psc_rsp_type o;
      at = {12'b0, r.raw_temperature};
      ap = {12'b0, r.raw_pressure};
      ah = {16'b0, r.raw_humidity};
      t1 = {16'b0, temp_trim[15:0]};
      t2 = sx(temp_trim, 16, 16); t3 = sx(temp_trim, 32, 16);
      p1 = {16'b0, press_lo[15:0]};
      p2 = sx(press_lo, 16, 16); p3 = sx(press_lo, 32, 16); p4 = sx(press_lo, 48, 16);
      p5 = sx(press_hi, 0, 16); p6 = sx(press_hi, 16, 16);
      p7 = sx(press_hi, 32, 16); p8 = sx(press_hi, 48, 16);
      p9 = sx({48'b0, press_p9}, 0, 16);
      h1 = {24'b0, hum_trim[7:0]}; h2 = sx(hum_trim, 8, 16);
      h3 = {24'b0, hum_trim[31:24]}; h4 = sx(hum_trim, 32, 12);
      h5 = sx(hum_trim, 44, 12); h6 = sx(hum_trim, 56, 8);
      // fine temperature
      a = asr(((at >> 3) - (t1 << 1)) * t2, 11);
      d = (at >> 4) - t1;
      b = asr(asr(d * d, 12) * t3, 14);
      tf = a + b;
      o.temperature_centi = asr(tf * 5 + TEMP_RND, 8);
      // pressure
      a = asr(tf, 1) - PRESS_OFS;
      d = asr(a, 2);
      b = asr(d * d, 11) * p6;
      b = b + ((a * p5) << 1);
      b = asr(b, 2) + (p4 << 16);
      a = asr(asr(p3 * asr(d * d, 13), 3) + asr(p2 * a, 1), 18);
      a = asr((P1_BIAS + a) * p1, 15);
      if (a == 0) begin
         o.pressure_invalid = 1'b1;
         o.pressure_pa = 0;
      end else begin
         o.pressure_invalid = 1'b0;
         p = ((PRESS_BASE - ap) - asr(b, 12)) * PRESS_SCALE;
         if (p < 32'h8000_0000) p = (p << 1) / a;
         else p = (p / a) * 2;
         a = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
         b = asr((p >> 2) * p8, 13);
         o.pressure_pa = p + asr(a + b + p7, 4);
      end
      // humidity
      a = tf - HUM_OFS;
      b = asr(((ah << 14) - (h4 << 20) - (h5 * a)) + HUM_RND, 15);
      d = asr(asr(a * h6, 10) * (asr(a * h3, 11) + P1_BIAS), 10) + HUM_BIAS;
      d = asr(d * h2 + HUM_RND2, 14);
      a = b * d;
      d = asr(a, 15);
      a = a - asr(asr(d * d, 7) * h1, 4);
      if (a[31]) a = 0;
      if (a > HUM_MAX_Q22) a = HUM_MAX_Q22;
      o.humidity_q10 = a[28:12];
      return o;
   endfunction

   always @(posedge clock) begin
      psc_rsp_type e;
      if (reset) begin
         temp_trim <= '0; press_lo <= '0; press_hi <= '0; press_p9 <= '0; hum_trim <= '0;
         expected_q.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         // trims are only written while idle, so old values apply to this edge's request
         if (start && !busy) expected_q.push_back(compensate(req_data));
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (e.temperature_centi !== rsp_data.temperature_centi ||
                   e.pressure_pa !== rsp_data.pressure_pa ||
                   e.pressure_invalid !== rsp_data.pressure_invalid ||
                   e.humidity_q10 !== rsp_data.humidity_q10) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_q.size();
         if (csr_we) begin
            case (csr_index)
               CSR_TEMP_TRIM:       temp_trim <= csr_wdata[47:0];
               CSR_PRESS_TRIM_LOW:  press_lo <= csr_wdata;
               CSR_PRESS_TRIM_HIGH: press_hi <= csr_wdata;
               CSR_PRESS_TRIM_LAST: press_p9 <= csr_wdata[15:0];
               CSR_HUM_TRIM:        hum_trim <= csr_wdata;
               default: ;
            endcase
         end
      end
   end
endmodule

### dv/tb.sv
// top of the compensation unit testbench: clock, reset, trim writes and request stimulus
// depends on psc_pkg, pressure_sensor_compensation_unit and psc_checker
`timescale 1ns / 100ps

module tb;
   import psc_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy, rsp_valid;
   psc_req_type req_data = '0;
   psc_rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int fail_count, pending_count;
   int idle_cycles;
   int sender_gap_pct;

   always #5 clock = ~clock;

   pressure_sensor_compensation_unit DUT (.*);
   psc_checker checker_i (.*);

   // watchdog: cycles with neither a request nor a result accepted
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_trim(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until nothing is in flight, then let the pipeline drain
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // send one request; holds start while busy, optional random gap first
   task automatic send(input psc_req_type r);
      while ($urandom_range(99) < sender_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1; req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic psc_req_type rand_req();
      psc_req_type r;
      r.raw_temperature = 20'($urandom);
      r.raw_pressure = 20'($urandom);
      r.raw_humidity = 16'($urandom);
      case ($urandom_range(5))
         0: r.raw_temperature = $urandom_range(1) ? '0 : '1;
         1: r.raw_pressure = $urandom_range(1) ? '0 : '1;
         2: r.raw_humidity = $urandom_range(1) ? '0 : '1;
         default: ;
      endcase
      return r;
   endfunction

   // all-zero, all-ones, realistic trims with random perturbation, random words with p1-p4 zero, or fully random
   task automatic load_trims(input int mode);
      logic [63:0] t, pl, ph, p9, h;
      case (mode)
         0: begin t = '0; pl = '0; ph = '0; p9 = '0; h = '0; end
         1: begin t = '1; pl = '1; ph = '1; p9 = '1; h = '1; end
         2: begin
            t = {16'h0000, 16'hFC18, 16'h6A8E, 16'h6E7C};
            pl = {16'h2710, 16'hD0A8, 16'hD61E, 16'h8E58};
            ph = {16'h3E80, 16'hC268, 16'hFFF9, 16'h00AC};
            p9 = 64'h1770;
            h = {8'h1E, 12'h032, 12'h146, 8'h00, 16'h016A, 8'h4B};
            t[15:0] = t[15:0] + 16'($urandom_range(63));
            pl[15:0] = pl[15:0] + 16'($urandom_range(63));
            h[7:0] = 8'($urandom);
         end
         3: begin
            pl = '0; // p1 zero forces the invalid-divisor case
            t = {$urandom, $urandom}; ph = {$urandom, $urandom};
            p9 = {32'b0, $urandom}; h = {$urandom, $urandom};
         end
         default: begin
            t = {$urandom, $urandom}; pl = {$urandom, $urandom};
            ph = {$urandom, $urandom}; p9 = {$urandom, $urandom};
            h = {$urandom, $urandom};
         end
      endcase
      write_trim(CSR_TEMP_TRIM, t);
      write_trim(CSR_PRESS_TRIM_LOW, pl);
      write_trim(CSR_PRESS_TRIM_HIGH, ph);
      write_trim(CSR_PRESS_TRIM_LAST, p9);
      write_trim(CSR_HUM_TRIM, h);
   endtask

   initial begin
      psc_req_type r;
      sender_gap_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and a typical request under the all-zero, all-ones, typical and zero-p1 trim sets
      for (int m = 0; m < 4; m++) begin
         load_trims(m);
         for (int k = 0; k < 6; k++) begin
            r.raw_temperature = (k & 1) ? '1 : '0;
            r.raw_pressure = (k & 2) ? '1 : '0;
            r.raw_humidity = (k & 4) ? '1 : '0;
            if (k == 5) r = '{20'h7E000, 20'h54000, 16'h6A00};
            send(r);
         end
         start <= 1'b0;
         drain();
      end

      // random phases: sender idles 20%, then 86%, then never
      for (int ph = 0; ph < 9; ph++) begin
         sender_gap_pct = (ph < 3) ? 20 : (ph < 6) ? 86 : 0;
         load_trims(ph % 3 == 0 ? 2 : (ph == 4 ? 3 : 4));
         for (int i = 0; i < 100; i++) begin
            send(rand_req());
            if (i == 50) begin
               // hold off until everything outstanding has come back
               start <= 1'b0;
               while (pending_count != 0) @(posedge clock);
            end
         end
         start <= 1'b0;
         drain();
      end

      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
